// File: sv/spg_pkg.sv
// Package for the sine PWM generator: register indexes, reset values, role codes,
// the sine table builder and the duty clamp.
// Depends on nothing; sine_pwm_generator refers to it by scoped names.
package spg_pkg;

	localparam int unsigned ACC_W    = 16;
	localparam int unsigned MOD_W    = 15;
	localparam int unsigned PERIOD_W = 10;
	localparam int unsigned SYNC_W   = 8;
	localparam int unsigned CMP_W    = 11;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_ROLE     = 3'd0;
	localparam logic [IDX_W-1:0] REG_INC      = 3'd1;
	localparam logic [IDX_W-1:0] REG_TARGET   = 3'd2;
	localparam logic [IDX_W-1:0] REG_STEP     = 3'd3;
	localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd4;
	localparam logic [IDX_W-1:0] REG_SYNC_LEN = 3'd5;

	localparam logic [1:0] ROLE_PRIMARY   = 2'd0;
	localparam logic [1:0] ROLE_SLAVE_240 = 2'd1;
	localparam logic [1:0] ROLE_SLAVE_120 = 2'd2;

	localparam logic [1:0]          RST_ROLE     = ROLE_PRIMARY;
	localparam logic [ACC_W-1:0]    RST_INC      = 16'd163;
	localparam logic [MOD_W-1:0]    RST_TARGET   = 15'd27307;
	localparam logic [MOD_W-1:0]    RST_STEP     = 15'd3;
	localparam logic [PERIOD_W-1:0] RST_PERIOD   = 10'd613;
	localparam logic [SYNC_W-1:0]   RST_SYNC_LEN = 8'd2;

	localparam logic [ACC_W-1:0] OFFSET_240 = 16'd43690;
	localparam logic [ACC_W-1:0] OFFSET_120 = 16'd21845;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
	localparam longint      Q31_TOP     = 64'sd2147417076;

	// Offset sine entry idx of a table with 2^table_bits entries, evaluated at
	// elaboration. One quadrant is computed with a Q30 Taylor series.
	function automatic logic [MOD_W-1:0] sine_entry(int unsigned table_bits,
		int unsigned idx);
		int unsigned qbits;
		int unsigned quad;
		int unsigned r;
		int unsigned rr;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sub;
		logic [63:0] s;
		logic [63:0] prod;
		longint      y2;
		logic [MOD_W-1:0] v;
		qbits = table_bits - 2;
		quad  = idx >> qbits;
		r     = idx & ((1 << qbits) - 1);
		rr    = ((quad & 1) != 0) ? (1 << qbits) - r : r;
		x     = (Q30_HALF_PI * 64'(rr)) >> qbits;
		x2    = (x * x) >> 30;
		t     = Q30_ONE;
		sub = ((x2 * t) >> 30) / 64'd272; t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd210; t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd156; t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd110; t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd72;  t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd42;  t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd20;  t = (sub >= t) ? 64'd0 : t - sub;
		sub = ((x2 * t) >> 30) / 64'd6;   t = (sub >= t) ? 64'd0 : t - sub;
		s = (x * t) >> 30;
		if (quad < 2) begin
			y2 = longint'(Q30_ONE) + longint'(s);
		end else begin
			y2 = longint'(Q30_ONE) - longint'(s);
		end
		if (y2 <= 0) begin
			v = '0;
		end else if (y2 >= Q31_TOP) begin
			v = 15'h7FFF;
		end else begin
			prod = (64'(y2) * 64'd32767 + 64'd1073741824) >> 31;
			v    = prod[MOD_W-1:0];
		end
		return v;
	endfunction

	// Duty to compare word: zero becomes one, a duty at or above the period
	// becomes period - 1, and the word is the duty doubled.
	function automatic logic [CMP_W-1:0] duty_word(logic [PERIOD_W-1:0] d,
		logic [PERIOD_W-1:0] period);
		logic [PERIOD_W-1:0] duty;
		duty = (d > period) ? period : d;
		if (duty == '0) begin
			duty = 10'd1;
		end
		if (duty >= period) begin
			duty = (period == '0) ? 10'd0 : period - 10'd1;
		end
		return {duty, 1'b0};
	endfunction

endpackage

// File: sv/sine_pwm_generator.sv
// An accepted input item passes through the states PHASE, LOOK, MUL1, PREP, MUL2 and FIN; FIN loads
// the result into the output register once it is free. The phase add is bit-serial over 16 bits, the
// modulation product over 15 bits and the period scaling over 10, one bit per cycle each.
// The next item is accepted while a finished result still waits in the output register.
// Reset (arst_n low, asynchronous) clears the accumulator, modulation, sync state and the
// handshakes, and loads the register defaults. The sine table is constant logic.
// Sine PWM generator top level: phase NCO, soft start, sine lookup and duty compare.
// Depends on spg_pkg.
module sine_pwm_generator #(
	parameter int unsigned TABLE_BITS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [0] sync_edge, [1] same_phase
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // [10:0] compare_a, [21:11] compare_b,
	                                                  // [22] sync_out
	input  logic                           cfg_we,
	input  logic [spg_pkg::IDX_W-1:0]      cfg_index,
	input  logic [spg_pkg::CFG_W-1:0]      cfg_data
);

	localparam int unsigned TableSize = 1 << TABLE_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PHASE = 3'd1;
	localparam logic [2:0] ST_LOOK  = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_PREP  = 3'd4;
	localparam logic [2:0] ST_MUL2  = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	// Configuration registers
	logic [1:0]                      role_q;
	logic [spg_pkg::ACC_W-1:0]       inc_q;
	logic [spg_pkg::MOD_W-1:0]       target_q;
	logic [spg_pkg::MOD_W-1:0]       step_q;
	logic [spg_pkg::PERIOD_W-1:0]    period_q;
	logic [spg_pkg::SYNC_W-1:0]      sync_len_q;

	// Tick state
	logic [spg_pkg::ACC_W-1:0]       acc_q;
	logic [spg_pkg::MOD_W-1:0]       mod_q;
	logic [spg_pkg::SYNC_W-1:0]      sync_cnt_q;
	logic                            sync_q;

	logic [2:0]                      state_q;
	logic [3:0]                      cnt_q;

	// Serial datapath registers
	logic [spg_pkg::ACC_W-1:0]       sh_inc_q;
	logic [spg_pkg::ACC_W-1:0]       sh_off_q;
	logic [spg_pkg::ACC_W-1:0]       theta_q;
	logic                            c_acc_q;
	logic                            c_theta_q;
	logic [spg_pkg::MOD_W-1:0]       sh_lvl_q;
	logic [spg_pkg::MOD_W-1:0]       sh_step_q;
	logic [spg_pkg::MOD_W-1:0]       sh_tgt_q;
	logic [spg_pkg::MOD_W-1:0]       sh_next_q;
	logic                            c_mod_q;
	logic                            lvl_lt_q;
	logic                            next_gt_q;
	logic [spg_pkg::MOD_W-1:0]       sine_q;
	logic [spg_pkg::MOD_W-1:0]       sh_mod_q;
	logic signed [16:0]              pacc_q;
	logic                            lo_nz_q;
	logic [spg_pkg::MOD_W-1:0]       ua_q;
	logic [spg_pkg::MOD_W-1:0]       ub_q;
	logic [spg_pkg::PERIOD_W-1:0]    sh_per_q;
	logic [spg_pkg::MOD_W-1:0]       acc_a_q;
	logic [spg_pkg::MOD_W-1:0]       acc_b_q;

	// Output register
	logic [spg_pkg::CMP_W-1:0]       out_a_q;
	logic [spg_pkg::CMP_W-1:0]       out_b_q;
	logic                            out_sync_q;

	logic [spg_pkg::MOD_W-1:0]       sine_rom [TableSize];

	for (genvar g = 0; g < TableSize; g++) begin : g_rom
		assign sine_rom[g] = spg_pkg::sine_entry(TABLE_BITS, g);
	end

	logic                            in_fire;
	logic                            out_free;
	logic                            slave;
	logic [spg_pkg::ACC_W-1:0]       offset;
	logic                            acc_sum;
	logic                            acc_cout;
	logic                            th_sum;
	logic                            th_cout;
	logic                            mod_sum;
	logic                            mod_cout;
	logic                            mod_active;
	logic                            wrap;
	logic [spg_pkg::SYNC_W-1:0]      cd_load;
	logic [spg_pkg::SYNC_W-1:0]      cd_dec;
	logic [spg_pkg::SYNC_W-1:0]      sync_cnt_d;
	logic                            sync_d;
	logic signed [16:0]              sine_bip;
	logic signed [16:0]              ptmp;
	logic [spg_pkg::MOD_W-1:0]       vb;
	logic [spg_pkg::MOD_W:0]         ta;
	logic [spg_pkg::MOD_W:0]         tb;
	logic                            fin_load;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;
	assign fin_load = (state_q == ST_FIN) && out_free;
	assign m_tdata  = {1'b0, out_sync_q, out_b_q, out_a_q};

	assign slave = (role_q == spg_pkg::ROLE_SLAVE_240) || (role_q == spg_pkg::ROLE_SLAVE_120);

	always_comb begin
		offset = '0;
		if (!s_tdata[1]) begin
			if (role_q == spg_pkg::ROLE_SLAVE_240) begin
				offset = spg_pkg::OFFSET_240;
			end else if (role_q == spg_pkg::ROLE_SLAVE_120) begin
				offset = spg_pkg::OFFSET_120;
			end
		end
	end

	// Full adders of the serial phase pass.
	assign acc_sum    = acc_q[0] ^ sh_inc_q[0] ^ c_acc_q;
	assign acc_cout   = (acc_q[0] & sh_inc_q[0]) | (c_acc_q & (acc_q[0] ^ sh_inc_q[0]));
	assign th_sum     = acc_sum ^ sh_off_q[0] ^ c_theta_q;
	assign th_cout    = (acc_sum & sh_off_q[0]) | (c_theta_q & (acc_sum ^ sh_off_q[0]));
	assign mod_sum    = sh_lvl_q[0] ^ sh_step_q[0] ^ c_mod_q;
	assign mod_cout   = (sh_lvl_q[0] & sh_step_q[0]) |
		(c_mod_q & (sh_lvl_q[0] ^ sh_step_q[0]));
	assign mod_active = (cnt_q != 4'd15);

	// The carry out of the top accumulator bit is the wrap.
	assign wrap    = acc_cout;
	assign cd_load = (sync_len_q == '0) ? 8'd1 : sync_len_q;

	always_comb begin
		sync_cnt_d = wrap ? cd_load : sync_cnt_q;
		sync_d     = wrap ? 1'b1 : sync_q;
		cd_dec     = sync_cnt_d - 8'd1;
		if (sync_cnt_d != '0) begin
			sync_cnt_d = cd_dec;
			if (cd_dec == '0) begin
				sync_d = 1'b0;
			end
		end
		if (slave) begin
			sync_cnt_d = '0;
			sync_d     = 1'b0;
		end
	end

	// Table value minus half scale is bit 14 flipped, read as signed.
	assign sine_bip = 17'(signed'(sine_q ^ 15'h4000));
	assign ptmp     = pacc_q + (sh_mod_q[0] ? sine_bip : 17'sd0);
	// Leg B takes floor of the negated product: -va, less one if low bits were set.
	assign vb       = (~pacc_q[14:0]) + {14'd0, ~lo_nz_q};
	assign ta       = {1'b0, acc_a_q} + (sh_per_q[0] ? {1'b0, ua_q} : 16'd0);
	assign tb       = {1'b0, acc_b_q} + (sh_per_q[0] ? {1'b0, ub_q} : 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_q     <= spg_pkg::RST_ROLE;
			inc_q      <= spg_pkg::RST_INC;
			target_q   <= spg_pkg::RST_TARGET;
			step_q     <= spg_pkg::RST_STEP;
			period_q   <= spg_pkg::RST_PERIOD;
			sync_len_q <= spg_pkg::RST_SYNC_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				spg_pkg::REG_ROLE:     role_q     <= cfg_data[1:0];
				spg_pkg::REG_INC:      inc_q      <= cfg_data;
				spg_pkg::REG_TARGET:   target_q   <= cfg_data[14:0];
				spg_pkg::REG_STEP:     step_q     <= cfg_data[14:0];
				spg_pkg::REG_PERIOD:   period_q   <= cfg_data[9:0];
				spg_pkg::REG_SYNC_LEN: sync_len_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			acc_q      <= '0;
			mod_q      <= '0;
			sync_cnt_q <= '0;
			sync_q     <= 1'b0;
			m_tvalid   <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && !fin_load) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (slave && s_tdata[0]) begin
							acc_q <= '0;
						end
						cnt_q   <= '0;
						state_q <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					acc_q <= {acc_sum, acc_q[15:1]};
					cnt_q <= cnt_q + 4'd1;
					if (!mod_active) begin
						sync_q     <= sync_d;
						sync_cnt_q <= sync_cnt_d;
						if (lvl_lt_q) begin
							mod_q <= (c_mod_q || next_gt_q) ? target_q : sh_next_q;
						end
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					cnt_q   <= '0;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd14) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd9) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sh_inc_q  <= inc_q;
				sh_off_q  <= offset;
				c_acc_q   <= 1'b0;
				c_theta_q <= 1'b0;
				sh_lvl_q  <= mod_q;
				sh_step_q <= step_q;
				sh_tgt_q  <= target_q;
				c_mod_q   <= 1'b0;
				lvl_lt_q  <= 1'b0;
				next_gt_q <= 1'b0;
			end
			ST_PHASE: begin
				sh_inc_q  <= sh_inc_q >> 1;
				sh_off_q  <= sh_off_q >> 1;
				c_acc_q   <= acc_cout;
				c_theta_q <= th_cout;
				theta_q   <= {th_sum, theta_q[15:1]};
				if (mod_active) begin
					sh_next_q <= {mod_sum, sh_next_q[14:1]};
					c_mod_q   <= mod_cout;
					// LSB-first compares: the highest differing bit decides.
					if (sh_lvl_q[0] != sh_tgt_q[0]) begin
						lvl_lt_q <= sh_tgt_q[0];
					end
					if (mod_sum != sh_tgt_q[0]) begin
						next_gt_q <= mod_sum;
					end
					sh_lvl_q  <= sh_lvl_q >> 1;
					sh_step_q <= sh_step_q >> 1;
					sh_tgt_q  <= sh_tgt_q >> 1;
				end
			end
			ST_LOOK: begin
				sine_q   <= sine_rom[theta_q[15 -: TABLE_BITS]];
				sh_mod_q <= mod_q;
				pacc_q   <= '0;
				lo_nz_q  <= 1'b0;
			end
			ST_MUL1: begin
				pacc_q   <= ptmp >>> 1;
				lo_nz_q  <= lo_nz_q | ptmp[0];
				sh_mod_q <= sh_mod_q >> 1;
			end
			ST_PREP: begin
				ua_q     <= pacc_q[14:0] ^ 15'h4000;
				ub_q     <= vb ^ 15'h4000;
				acc_a_q  <= '0;
				acc_b_q  <= '0;
				sh_per_q <= period_q;
			end
			ST_MUL2: begin
				acc_a_q  <= ta[15:1];
				acc_b_q  <= tb[15:1];
				sh_per_q <= sh_per_q >> 1;
			end
			ST_FIN: begin
				if (out_free) begin
					out_a_q    <= spg_pkg::duty_word(acc_a_q[14:5], period_q);
					out_b_q    <= spg_pkg::duty_word(acc_b_q[14:5], period_q);
					out_sync_q <= sync_q;
				end
			end
			default: ;
		endcase
	end

endmodule
